### src/oee_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the byte classifier for the octal escape encoder.
// Depends on nothing; every other file of the block imports it.
package oee_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] BUDGET_RESET = 16'd255;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // Byte class; as a command kind, CLS_END means no characters to write.
    typedef enum logic [1:0] {
        CLS_END,
        CLS_PASS,
        CLS_ESC,
        CLS_OCT
    } t_cls;

    typedef struct packed {
        t_cls        kind;
        logic [7:0]  data;    // source byte, or the escape letter for CLS_ESC
    } t_class;

    // One queued command: the characters of one source byte plus the terminator flag.
    typedef struct packed {
        t_cls        kind;
        logic [7:0]  data;
        logic        finish;
        logic [15:0] base;    // count before the first character of this command
    } t_cmd;

    function automatic t_class classify(input logic [7:0] c);
        t_class r;
        r.data = c;
        r.kind = CLS_PASS;
        case (c)
            8'd0:   r.kind = CLS_END;
            8'd7:   begin r.kind = CLS_ESC; r.data = 8'h61; end  // a
            8'd8:   begin r.kind = CLS_ESC; r.data = 8'h62; end  // b
            8'd9:   begin r.kind = CLS_ESC; r.data = 8'h74; end  // t
            8'd10:  begin r.kind = CLS_ESC; r.data = 8'h6E; end  // n
            8'd11:  begin r.kind = CLS_ESC; r.data = 8'h76; end  // v
            8'd12:  begin r.kind = CLS_ESC; r.data = 8'h66; end  // f
            8'd13:  begin r.kind = CLS_ESC; r.data = 8'h72; end  // r
            8'd27:  begin r.kind = CLS_ESC; r.data = 8'h65; end  // e
            8'd32:  begin r.kind = CLS_ESC; r.data = 8'h20; end  // space
            8'd92:  begin r.kind = CLS_ESC; r.data = CH_BSLASH; end
            8'd127: r.kind = CLS_OCT;
            default: begin
                if (c < 8'd32) begin
                    r.kind = CLS_OCT;
                end else if (c >= 8'd128 && c < 8'd160) begin
                    r.kind = CLS_OCT;
                end
            end
        endcase
        return r;
    endfunction

    // Number of characters a command writes before its optional terminator.
    function automatic logic [2:0] cmd_len(input t_cls k);
        logic [2:0] n;
        case (k)
            CLS_PASS: n = 3'd1;
            CLS_ESC:  n = 3'd2;
            CLS_OCT:  n = 3'd4;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

### src/oee_front.sv
`timescale 1ns / 1ps
// Front end: accepts source bytes, tracks the written count and string end
// against the budget, queuing one command per byte until it ends. Uses oee_pkg.
module oee_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_source_byte,
    input  logic          i_start_of_string,
    input  logic [15:0]   i_budget,
    output logic          o_cmd_push,
    output oee_pkg::t_cmd o_cmd
);
    import oee_pkg::*;

    logic [15:0] r_count, n_count;
    logic        r_done,  n_done;

    logic [15:0] cnt0;
    logic        done0;
    logic [16:0] need;
    t_class      cls;
    logic        finish;

    // Decide what this byte produces and where the count ends up.
    always_comb begin
        cnt0   = i_start_of_string ? 16'd0 : r_count;
        done0  = i_start_of_string ? 1'b0 : r_done;
        cls    = classify(i_source_byte);
        need   = {1'b0, cnt0} + {14'd0, cmd_len(cls.kind)};
        finish = 1'b0;
        n_count = cnt0;
        o_cmd.kind = CLS_END;
        o_cmd.data = cls.data;
        o_cmd.base = cnt0;
        if (cnt0 >= i_budget) begin
            finish = 1'b1;
        end else begin
            if (cls.kind == CLS_END || need > {1'b0, i_budget}) begin
                finish = 1'b1;
            end else begin
                o_cmd.kind = cls.kind;
                n_count    = need[15:0];
                if (need[15:0] >= i_budget) begin
                    finish = 1'b1;
                end
            end
        end
        o_cmd.finish = finish;
        n_done       = done0 | finish;
        o_cmd_push   = i_accept & ~done0;
    end

    // Per-string state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 16'd0;
            r_done  <= 1'b1;
        end else if (i_accept) begin
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

endmodule

### src/oee_fifo.sv
`timescale 1ns / 1ps
// Short command queue between front and back end, read from the head.
// Uses oee_pkg for the command type and depth.
module oee_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  oee_pkg::t_cmd i_data,
    input  logic          i_pop,
    output oee_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);
    import oee_pkg::*;

    t_cmd                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // Storage; a push is only made while not full.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### src/oee_back.sv
`timescale 1ns / 1ps
// Back end: expands each queued command into result word characters, one per
// cycle while the registered result word is empty or popped. Uses oee_pkg.
module oee_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  oee_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_char,
    output logic          o_is_last,
    output logic [15:0]   o_char_count
);
    import oee_pkg::*;

    logic        r_valid;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_char, n_char;
    logic        r_last, n_last;
    logic [15:0] r_count, n_count;

    logic [2:0]  len;
    logic        advance;
    logic        cmd_done;

    // Pick the character at the current position of the head command.
    always_comb begin
        len      = cmd_len(i_cmd.kind);
        advance  = ~i_cmd_empty & (~r_valid | i_pop);
        n_last   = (r_idx == len);
        cmd_done = i_cmd.finish ? n_last : (r_idx == len - 3'd1);
        n_char   = i_cmd.data;
        case (i_cmd.kind)
            CLS_ESC: begin
                if (r_idx == 3'd0) n_char = CH_BSLASH;
            end
            CLS_OCT: begin
                case (r_idx)
                    3'd0:    n_char = CH_BSLASH;
                    3'd1:    n_char = CH_ZERO | {6'd0, i_cmd.data[7:6]};
                    3'd2:    n_char = CH_ZERO | {5'd0, i_cmd.data[5:3]};
                    default: n_char = CH_ZERO | {5'd0, i_cmd.data[2:0]};
                endcase
            end
            default: n_char = i_cmd.data;
        endcase
        if (n_last) begin
            n_char = CH_NUL;
        end
        n_count   = i_cmd.base + {13'd0, r_idx} + {15'd0, ~n_last};
        n_idx     = cmd_done ? 3'd0 : r_idx + 3'd1;
        o_cmd_pop = advance & cmd_done;
    end

    // Position within the head command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx <= n_idx;
            end
            if (advance) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_char  <= n_char;
            r_last  <= n_last;
            r_count <= n_count;
        end
    end

    assign o_empty      = ~r_valid;
    assign o_out_char   = r_char;
    assign o_is_last    = r_last;
    assign o_char_count = r_count;

endmodule

### src/octal_escape_encoder.sv
`timescale 1ns / 1ps
// Octal string escaper: takes one source byte per word and writes a sanitized
// copy, one character per result word, ending each string with a NUL word that
// carries the final count. A byte is taken whenever the four-entry command
// queue has room; the result side writes one character per cycle while its
// word is empty or popped; a pass-through byte writes one, a letter escape two,
// an octal escape four, the terminator one more; the result port sets the
// sustained rate. Bytes go through the command queue, then the result word
// register. Top level; uses oee_pkg, oee_front, oee_fifo, oee_back.
module octal_escape_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_source_byte,
    input  logic        i_start_of_string,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_char,
    output logic        o_is_last,
    output logic [15:0] o_char_count
);
    import oee_pkg::*;

    logic [15:0] r_budget;
    logic        accept;
    logic        cmd_push;
    logic        cmd_pop;
    logic        cmd_empty;
    t_cmd        cmd_in;
    t_cmd        cmd_head;

    // Output budget register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BUDGET_RESET;
        end else if (i_cfg_we) begin
            r_budget <= i_cfg_wdata;
        end
    end

    assign accept = push & ~full;

    oee_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_source_byte     (i_source_byte),
        .i_start_of_string (i_start_of_string),
        .i_budget          (r_budget),
        .o_cmd_push        (cmd_push),
        .o_cmd             (cmd_in)
    );

    oee_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_head  (cmd_head),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    oee_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_head),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_char   (o_out_char),
        .o_is_last    (o_is_last),
        .o_char_count (o_char_count)
    );

endmodule
